// ===== src/rau_pkg.sv =====
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int RES_NUM_WIDTH = 2 * OPERAND_WIDTH + 1;
  localparam int RES_DEN_WIDTH = 2 * OPERAND_WIDTH;
  localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH + 2;
  localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);
  localparam int CMD_WIDTH     = 2;

  localparam logic [CMD_WIDTH-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_MUL    = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_REDUCE = 2'd2;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_GCD  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

endpackage

// ===== src/rau_op_if.sv =====
interface rau_op_if;
  import rau_pkg::*;

  logic                            valid;
  logic                            ready;
  logic [CMD_WIDTH-1:0]            command;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic [OPERAND_WIDTH-1:0]        a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic [OPERAND_WIDTH-1:0]        b_den;

  modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface

// ===== src/rau_res_if.sv =====
interface rau_res_if;
  import rau_pkg::*;

  logic                            valid;
  logic                            ready;
  logic signed [RES_NUM_WIDTH-1:0] res_num;
  logic [RES_DEN_WIDTH-1:0]        res_den;
  logic                            status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

// ===== src/rational_arith_unit_core.sv =====
// channel    dir  payload                                   transfer
// operands   in   command, a_num, a_den, b_num, b_den       valid & ready
// result     out  res_num, res_den, status                  valid & ready
//
// sequencing: add and multiply step the multiplier through its products;
//   command three and zero-over-zero reduce go straight to the result;
//   reduce runs binary gcd steps, then the divider over numerator and denominator.
// the gcd compare and divider trial share one subtractor, and all products come from one multiplier.
// rst is synchronous and clears the sequencer and the result valid.
// operands are taken only while idle; a waiting result does not block the next transfer.
module rational_arith_unit_core (
  input  logic        clk,
  input  logic        rst,
  rau_op_if.sink      operands,
  rau_res_if.source   result
);
  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH;

  state_t state;

  logic [CMD_WIDTH-1:0]            cmd;
  logic signed [W-1:0]             an;
  logic [W-1:0]                    ad;
  logic signed [W-1:0]             bn;
  logic [W-1:0]                    bd;
  logic                            neg;
  logic [W-1:0]                    mag;
  logic [RES_NUM_WIDTH-1:0]        num;
  logic [RES_DEN_WIDTH-1:0]        den;
  logic                            st;
  logic signed [PROD_WIDTH-1:0]    prod;
  logic [1:0]                      mstep;
  logic [W-1:0]                    u;
  logic [W-1:0]                    v;
  logic [CNT_WIDTH-1:0]            k;
  logic [W-1:0]                    g;
  logic [W-1:0]                    rem;
  logic [W-1:0]                    quo;
  logic [CNT_WIDTH-1:0]            cnt;
  logic                            dpass;

  logic signed [W:0]               ma;
  logic signed [W:0]               mb;
  logic [W:0]                      sub_a;
  logic [W:0]                      sub_b;
  logic [W+1:0]                    sub_diff;
  logic                            borrow;
  logic [W-1:0]                    quo_next;
  logic [RES_NUM_WIDTH-1:0]        qn;
  logic [W-1:0]                    mag_in;
  logic                            accept;
  logic                            load_out;

  assign operands.ready = (state == S_IDLE);
  assign accept         = operands.valid && operands.ready;
  assign load_out       = (state == S_FIN) && (!result.valid || result.ready);

  // magnitude of the incoming numerator
  assign mag_in = operands.a_num[W-1] ? W'(-operands.a_num) : W'(operands.a_num);

  // multiplier operand select per step
  always_comb begin
    case (mstep)
      2'd0: begin
        ma = {an[W-1], an};
        mb = (cmd == CMD_ADD) ? $signed({1'b0, bd}) : $signed({bn[W-1], bn});
      end
      2'd1: begin
        ma = $signed({1'b0, ad});
        mb = (cmd == CMD_ADD) ? $signed({bn[W-1], bn}) : $signed({1'b0, bd});
      end
      default: begin
        ma = $signed({1'b0, ad});
        mb = $signed({1'b0, bd});
      end
    endcase
  end

  // shared subtractor: gcd compare or divider trial
  always_comb begin
    if (state == S_DIV) begin
      sub_a = {rem, quo[W-1]};
      sub_b = {1'b0, g};
    end else begin
      sub_a = {1'b0, u};
      sub_b = {1'b0, v};
    end
    sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  end

  assign borrow   = sub_diff[W+1];
  assign quo_next = {quo[W-2:0], ~borrow};
  assign qn       = RES_NUM_WIDTH'(quo_next);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd   <= operands.command;
            an    <= operands.a_num;
            ad    <= operands.a_den;
            bn    <= operands.b_num;
            bd    <= operands.b_den;
            mstep <= 2'd0;
            case (operands.command)
              CMD_ADD, CMD_MUL: begin
                state <= S_MUL;
              end
              CMD_REDUCE: begin
                if (mag_in == '0 && operands.a_den == '0) begin
                  num   <= RES_NUM_WIDTH'(operands.a_num);
                  den   <= RES_DEN_WIDTH'(operands.a_den);
                  st    <= 1'b1;
                  state <= S_FIN;
                end else begin
                  u     <= mag_in;
                  v     <= operands.a_den;
                  mag   <= mag_in;
                  neg   <= operands.a_num[W-1];
                  k     <= '0;
                  state <= S_GCD;
                end
              end
              default: begin
                num   <= RES_NUM_WIDTH'(operands.a_num);
                den   <= RES_DEN_WIDTH'(operands.a_den);
                st    <= 1'b0;
                state <= S_FIN;
              end
            endcase
          end
        end
        S_MUL: begin
          prod  <= ma * mb;
          mstep <= mstep + 2'd1;
          case (mstep)
            2'd1: begin
              num <= prod[RES_NUM_WIDTH-1:0];
            end
            2'd2: begin
              if (cmd == CMD_ADD) begin
                num <= num + prod[RES_NUM_WIDTH-1:0];
              end else begin
                den   <= prod[RES_DEN_WIDTH-1:0];
                st    <= 1'b0;
                state <= S_FIN;
              end
            end
            2'd3: begin
              den   <= prod[RES_DEN_WIDTH-1:0];
              st    <= 1'b0;
              state <= S_FIN;
            end
            default: begin
            end
          endcase
        end
        S_GCD: begin
          // binary gcd, one step a cycle
          if (u == '0 || v == '0) begin
            g     <= (u == '0) ? (v << k) : (u << k);
            rem   <= '0;
            quo   <= mag;
            cnt   <= '0;
            dpass <= 1'b0;
            state <= S_DIV;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + CNT_WIDTH'(1);
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (borrow) begin
            u <= v;
            v <= u;
          end else begin
            u <= sub_diff[W:1];
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle
          if (cnt == CNT_WIDTH'(W - 1) && !dpass) begin
            // numerator done, reload for the denominator pass
            num   <= neg ? -qn : qn;
            rem   <= '0;
            quo   <= ad;
            cnt   <= '0;
            dpass <= 1'b1;
          end else begin
            rem <= borrow ? sub_a[W-1:0] : sub_diff[W-1:0];
            quo <= quo_next;
            cnt <= cnt + CNT_WIDTH'(1);
            if (cnt == CNT_WIDTH'(W - 1)) begin
              den   <= RES_DEN_WIDTH'(quo_next);
              st    <= 1'b0;
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.res_num <= num;
      result.res_den <= den;
      result.status  <= st;
    end
  end

  // checks
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("sequencer stayed idle after operand transfer");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> g != '0)
    else $error("divider running with zero gcd");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status |-> result.res_num == '0 && result.res_den == '0)
    else $error("error status on a fraction other than zero over zero");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> result.valid)
    else $error("finished result not presented");

endmodule
